[design/epfat_pkg.sv]
// constants, tables and helpers for the epoch to fat timestamp converter
// no dependencies
package epfat_pkg;

    localparam logic [63:0] EPOCH_1980 = 64'd315532800;
    localparam logic [63:0] FAT_LAST   = 64'd4354819199;
    localparam logic [31:0] LAST_OFF   = 32'(FAT_LAST - EPOCH_1980);

    localparam int NUM_YEARS = 128;
    localparam int YEAR_BITS = $clog2(NUM_YEARS);
    localparam logic [YEAR_BITS-1:0] YEAR_2100 = YEAR_BITS'(2100 - 1980);

    // off / 86400 == ((off >> 7) * DAY_RECIP) >> DAY_SHIFT for off < 2^32
    localparam logic [25:0] DAY_RECIP = 26'd50903317;
    localparam int          DAY_SHIFT = 35;
    // rem / 3600 == ((rem >> 4) * HOUR_RECIP) >> HOUR_SHIFT for rem < 86400
    localparam logic [13:0] HOUR_RECIP = 14'd9321;
    localparam int          HOUR_SHIFT = 21;
    // rem / 60 == ((rem >> 2) * MIN_RECIP) >> MIN_SHIFT for rem < 3600
    localparam logic [10:0] MIN_RECIP = 11'd1093;
    localparam int          MIN_SHIFT = 14;

    localparam logic [5:0] FINE_ODD = 6'd50;

    typedef logic [15:0] t_day;
    typedef t_day t_year_tab [NUM_YEARS];

    function automatic bit is_leap(input int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic t_year_tab gen_year_tab();
        t_year_tab tab;
        int acc;
        acc = 0;
        for (int i = 0; i < NUM_YEARS; i++) begin
            tab[i] = t_day'(acc);
            acc += is_leap(1980 + i) ? 366 : 365;
        end
        return tab;
    endfunction

    // first day of each year since 1980, counted from 1980-01-01
    localparam t_year_tab YEAR_START = gen_year_tab();

    // day of year on which month m (0-based) begins
    function automatic logic [8:0] month_start(input logic [3:0] m, input logic lp);
        logic [8:0] s;
        case (m)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd59;
            4'd3:    s = 9'd90;
            4'd4:    s = 9'd120;
            4'd5:    s = 9'd151;
            4'd6:    s = 9'd181;
            4'd7:    s = 9'd212;
            4'd8:    s = 9'd243;
            4'd9:    s = 9'd273;
            4'd10:   s = 9'd304;
            4'd11:   s = 9'd334;
            default: s = 9'd0;
        endcase
        if (lp && m >= 4'd2) begin
            s = s + 9'd1;
        end
        return s;
    endfunction

endpackage

[design/epoch_to_fat_timestamp.sv]
// epoch to fat timestamp converter, fully pipelined top level
// depends on epfat_pkg
//
//  channel  | ports                                     | handshake
//  ---------+-------------------------------------------+---------------------------
//  command  | i_epoch_seconds                           | start high, busy low
//  result   | o_date_word o_time_word o_odd_second_fine | o_done, one cycle, no stall
//           | o_was_clamped                             |
//
// thirteen register stages: input, clamp, day reciprocal multiply, remainder, a seven step
// binary search of the year start table (one step per stage, time fields computed
// alongside), month select and packing. an item may enter every cycle; its result
// shows on o_done together with the packing stage output. busy is always low.
// reset clears only the valid bits of the stages.
module epoch_to_fat_timestamp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_epoch_seconds,
    output logic        o_done,
    output logic [15:0] o_date_word,
    output logic [15:0] o_time_word,
    output logic [5:0]  o_odd_second_fine,
    output logic        o_was_clamped
);
    import epfat_pkg::*;

    localparam int ST_IN  = 0;
    localparam int ST_OFF = 1;
    localparam int ST_MUL = 2;
    localparam int ST_DAY = 3;
    localparam int ST_S0  = ST_DAY + 1;
    localparam int ST_TW  = ST_S0 + 3;
    localparam int ST_MON = ST_S0 + YEAR_BITS;
    localparam int ST_OUT = ST_MON + 1;

    logic r_vld  [0:ST_OUT];
    logic r_clmp [ST_OFF:ST_OUT];

    logic [63:0] r_e;
    logic [31:0] r_off1, r_off2;
    logic [50:0] r_prod;
    logic [16:0] r_rem;

    // year search
    logic [15:0]          r_sdays [0:YEAR_BITS];
    logic [YEAR_BITS-1:0] r_sidx  [0:YEAR_BITS];

    // time of day
    logic [26:0] r_hp;
    logic [16:0] r_trem;
    logic [4:0]  r_hour1, r_hour2;
    logic [11:0] r_rem2, r_rem2b;
    logic [20:0] r_mp;
    logic [15:0] r_twd   [ST_TW:ST_MON];
    logic [5:0]  r_fined [ST_TW:ST_MON];

    // month
    logic [8:0]           r_dy;
    logic [3:0]           r_mon;
    logic                 r_lp;
    logic [YEAR_BITS-1:0] r_yr;

    logic [31:0] n_off;
    logic        n_clmp;
    logic [15:0] n_days;
    logic [8:0]  n_dy;
    logic        n_lp;
    logic [3:0]  n_mon;
    logic [4:0]  n_hour, n_min;
    logic [5:0]  n_minw, n_sec;
    logic [4:0]  n_day;

    assign busy = 1'b0;

    always_comb begin
        if (r_e[63] || r_e < EPOCH_1980) begin
            n_off  = '0;
            n_clmp = 1'b1;
        end else if (r_e > FAT_LAST) begin
            n_off  = LAST_OFF;
            n_clmp = 1'b1;
        end else begin
            n_off  = 32'(r_e - EPOCH_1980);
            n_clmp = 1'b0;
        end
    end

    assign n_days = r_prod[DAY_SHIFT +: 16];
    assign n_hour = 5'(r_hp >> HOUR_SHIFT);
    assign n_minw = 6'(r_mp >> MIN_SHIFT);
    assign n_min  = n_minw[4:0];
    assign n_sec  = 6'(r_rem2b - 12'(n_minw) * 12'd60);

    always_comb begin
        n_dy  = 9'(r_sdays[YEAR_BITS] - YEAR_START[r_sidx[YEAR_BITS]]);
        n_lp  = (r_sidx[YEAR_BITS][1:0] == 2'd0) && (r_sidx[YEAR_BITS] != YEAR_2100);
        n_mon = 4'd0;
        for (int k = 1; k < 12; k++) begin
            if (n_dy >= month_start(4'(k), n_lp)) begin
                n_mon = 4'(k);
            end
        end
    end

    assign n_day = 5'(r_dy - month_start(r_mon, r_lp) + 9'd1);

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= ST_OUT; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            r_vld[ST_IN] <= start && !busy;
            for (int s = 1; s <= ST_OUT; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_e <= i_epoch_seconds;

        r_off1        <= n_off;
        r_clmp[ST_OFF] <= n_clmp;
        for (int s = ST_OFF + 1; s <= ST_OUT; s++) begin
            r_clmp[s] <= r_clmp[s-1];
        end

        r_prod <= 51'(r_off1[31:7]) * 51'(DAY_RECIP);
        r_off2 <= r_off1;

        r_sdays[0] <= n_days;
        r_sidx[0]  <= '0;
        r_rem      <= 17'(r_off2 - 32'(n_days) * 32'd86400);

        r_hp    <= 27'(r_rem[16:4]) * 27'(HOUR_RECIP);
        r_trem  <= r_rem;
        r_hour1 <= n_hour;
        r_rem2  <= 12'(r_trem - 17'(n_hour) * 17'd3600);
        r_hour2 <= r_hour1;
        r_mp    <= 21'(r_rem2[11:2]) * 21'(MIN_RECIP);
        r_rem2b <= r_rem2;
        r_twd[ST_TW]   <= {r_hour2, n_minw, n_sec[5:1]};
        r_fined[ST_TW] <= n_sec[0] ? FINE_ODD : 6'd0;
        for (int s = ST_TW + 1; s <= ST_MON; s++) begin
            r_twd[s]   <= r_twd[s-1];
            r_fined[s] <= r_fined[s-1];
        end

        r_dy  <= n_dy;
        r_lp  <= n_lp;
        r_mon <= n_mon;
        r_yr  <= r_sidx[YEAR_BITS];

        o_date_word       <= {r_yr, r_mon + 4'd1, n_day};
        o_time_word       <= r_twd[ST_MON];
        o_odd_second_fine <= r_fined[ST_MON];
        o_was_clamped     <= r_clmp[ST_MON];
    end

    assign o_done = r_vld[ST_OUT];

    // binary search over year starts, one bit per stage
    for (genvar s = 0; s < YEAR_BITS; s++) begin : g_year
        logic [YEAR_BITS-1:0] w_cand;
        assign w_cand = r_sidx[s] | YEAR_BITS'(1 << (YEAR_BITS - 1 - s));
        always_ff @(posedge i_clk) begin
            r_sdays[s+1] <= r_sdays[s];
            r_sidx[s+1]  <= (r_sdays[s] >= YEAR_START[w_cand]) ? w_cand : r_sidx[s];
        end
    end

    // unused result bits kept quiet
    logic w_unused;
    assign w_unused = ^{n_min, r_prod[DAY_SHIFT-1:0], r_off2[31:17]};

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##13 o_done)
        else $error("result strobe missing after accepted item");

    a_clamp_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_was_clamped |-> (o_date_word == 16'h0021 || o_date_word == 16'hFF9F))
        else $error("clamped item gives a date other than the range ends");

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_date_word[8:5] != 4'd0 && o_date_word[8:5] <= 4'd12
                    && o_date_word[4:0] != 5'd0))
        else $error("month or day out of range");

endmodule
